[rtl/core/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and fixed constants of the greedy box suppression core.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int FIELD_BITS   = 16;
   localparam int THR_BITS     = 16;
   localparam int SLOT_BITS    = 6;
   localparam int REQ_DATA_W   = 4 * FIELD_BITS;
   localparam int REQ_USER_W   = 1;
   localparam int RSP_DATA_W   = 24;
   localparam int RSP_USER_W   = 2;

   // 0.45 with 16 fractional bits.
   localparam logic [THR_BITS-1:0] THR_RESET = 16'd29491;

   // Status reported by the compare pipeline to the sequencer.
   typedef struct packed {
      logic busy;
      logic hit;
   } gbn_scan_stat_type;

endpackage

[rtl/core/gbn_ram.sv]
// ----------------------------------------------------------------------------
// gbn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ABITS-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [ABITS-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/gbn_scan.sv]
// ----------------------------------------------------------------------------
// gbn_scan
// Compare pipeline: overlap of the current box with one stored box per cycle,
// then the cross-multiplied overlap test, folded into a sticky hit flag.
// ----------------------------------------------------------------------------
module gbn_scan #(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      rd_fire,
   input  logic [4*COORD_BITS-1:0]   cur_box,
   input  logic [2*COORD_BITS-1:0]   cur_area,
   input  logic [gbn_pkg::THR_BITS-1:0] thr,
   input  logic [4*COORD_BITS-1:0]   kept_box,
   input  logic [2*COORD_BITS-1:0]   kept_area,
   output gbn_pkg::gbn_scan_stat_type stat
);
   import gbn_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int AW = 2 * C;
   localparam int UW = 2 * C + 1;
   localparam int BW = UW + 17;

   logic signed [C-1:0] cx0, cy0, cx1, cy1, kx0, ky0, kx1, ky1;
   logic signed [C-1:0] lft, top, rgt, btm;
   logic signed [C:0]   dx, dy;
   logic [C-1:0]        iw_in, ih_in, iw_ff, ih_ff;
   logic [AW-1:0]       ka_ff;
   logic [AW-1:0]       inter2_in, inter2_ff, inter3_ff, inter4_ff;
   logic [UW-1:0]       asum_in, asum_ff;
   logic [UW-1:0]       uni_in, uni_ff;
   logic [UW-1:0]       phi_in, phi_ff;
   logic [31:0]         plo_in, plo_ff;
   logic                nz_ff;
   logic [BW-1:0]       lhs, rhs;
   logic                v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic                hit_in, hit_ff;

   assign cx0 = cur_box[C-1:0];
   assign cy0 = cur_box[2*C-1:C];
   assign cx1 = cur_box[3*C-1:2*C];
   assign cy1 = cur_box[4*C-1:3*C];
   assign kx0 = kept_box[C-1:0];
   assign ky0 = kept_box[2*C-1:C];
   assign kx1 = kept_box[3*C-1:2*C];
   assign ky1 = kept_box[4*C-1:3*C];

   // Stage A: intersection edges from the RAM read data.
   always_comb begin
      lft   = (cx0 > kx0) ? cx0 : kx0;
      top   = (cy0 > ky0) ? cy0 : ky0;
      rgt   = (cx1 < kx1) ? cx1 : kx1;
      btm   = (cy1 < ky1) ? cy1 : ky1;
      dx    = (C+1)'(rgt) - (C+1)'(lft);
      dy    = (C+1)'(btm) - (C+1)'(top);
      iw_in = (dx > 0) ? dx[C-1:0] : '0;
      ih_in = (dy > 0) ? dy[C-1:0] : '0;
   end

   // Stage B: intersection area and sum of both areas.
   assign inter2_in = AW'(iw_ff) * AW'(ih_ff);
   assign asum_in   = UW'(cur_area) + UW'(ka_ff);

   // Stage C: union.
   assign uni_in = asum_ff - UW'(inter2_ff);

   // Stage D: threshold times union, split in a high and a low partial product.
   assign phi_in = UW'(thr) * UW'(uni_ff[UW-1:16]);
   assign plo_in = 32'(thr) * 32'(uni_ff[15:0]);

   // Stage E: intersection * 2^16 > threshold * union, ignored for empty union.
   assign lhs    = BW'(inter4_ff) << 16;
   assign rhs    = (BW'(phi_ff) << 16) + BW'(plo_ff);
   assign hit_in = hit_ff | (v4_ff & nz_ff & (lhs > rhs));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v0_ff  <= rd_fire;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         hit_ff <= start ? 1'b0 : hit_in;
      end
   end

   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      ka_ff     <= kept_area;
      inter2_ff <= inter2_in;
      asum_ff   <= asum_in;
      inter3_ff <= inter2_ff;
      uni_ff    <= uni_in;
      inter4_ff <= inter3_ff;
      phi_ff    <= phi_in;
      plo_ff    <= plo_in;
      nz_ff     <= (uni_ff != '0);
   end

   assign stat.busy = v0_ff | v1_ff | v2_ff | v3_ff | v4_ff;
   assign stat.hit  = hit_ff;

endmodule

[rtl/core/greedy_box_nms_core.sv]
// ----------------------------------------------------------------------------
// greedy_box_nms_core
// Greedy non-maximum suppression over score-ordered boxes with a kept-box store.
// ----------------------------------------------------------------------------
// Each request runs through the states AREA, SCAN, DRAIN and DONE before its response.
// The compare pipeline reads one stored box per cycle, so the store fill sets the scan
//   length; a request is handled to its response before the next one is taken.
// A new request is taken while the previous response still waits to be taken.
// Reset (synchronous, active high) empties the store, zeroes the set position and
//   loads the IoU threshold with 0.45; the RAM contents are not cleared.
module greedy_box_nms_core #(
   parameter int MAX_KEPT   = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // x_left[15:0], y_top[31:16], x_right[47:32], y_bottom[63:48]
   input  logic [gbn_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_in_set[0]
   input  logic [gbn_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // box_index[15:0], kept_slot[21:16], zero fill[23:22]
   output logic [gbn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // keep[0], store_full[1]
   output logic [gbn_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [gbn_pkg::THR_BITS-1:0]   csr_wdata,
   input  logic                           csr_valid,
   output logic                           csr_ready
);
   import gbn_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int TAKE = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW   = $clog2(MAX_KEPT + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_KEPT);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_AREA  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [THR_BITS-1:0] thr_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       addr_ff, addr_in;
   logic [15:0]         setpos_ff, setpos_in, pos;
   logic [15:0]         idx_ff;
   logic [4*C-1:0]      box_ff, box_in;
   logic [C-1:0]        ew_ff, eh_ff, ew_in, eh_in;
   logic [2*C-1:0]      area_ff;
   logic                rsp_valid_ff;
   logic                rsp_keep_ff, rsp_full_ff;
   logic [15:0]         rsp_idx_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff;

   logic signed [TAKE-1:0] rx0, ry0, rx1, ry1;
   logic signed [C-1:0]    x0, y0, x1, y1;
   logic signed [C:0]      dx, dy;
   logic                   req_fire, out_free, done_fire, keep, room, wr_en, rd_fire;
   logic [AW+SLOT_BITS-1:0] slot_wide;
   logic [4*C-1:0]         kbox_rd;
   logic [2*C-1:0]         karea_rd;
   gbn_scan_stat_type      scan_stat;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign done_fire  = (state_ff == ST_DONE) & out_free;
   assign keep       = ~scan_stat.hit;
   assign room       = (count_ff < COUNT_MAX);
   assign wr_en      = done_fire & keep & room;
   assign rd_fire    = (state_ff == ST_SCAN) & (addr_ff < count_ff);
   assign slot_wide  = {{SLOT_BITS{1'b0}}, count_ff[AW-1:0]};

   // Only the low coordinate bits are used, sign extended.
   assign rx0 = req_tdata[TAKE-1:0];
   assign ry0 = req_tdata[FIELD_BITS+TAKE-1:FIELD_BITS];
   assign rx1 = req_tdata[2*FIELD_BITS+TAKE-1:2*FIELD_BITS];
   assign ry1 = req_tdata[3*FIELD_BITS+TAKE-1:3*FIELD_BITS];
   assign x0  = C'(rx0);
   assign y0  = C'(ry0);
   assign x1  = C'(rx1);
   assign y1  = C'(ry1);
   assign dx  = (C+1)'(x1) - (C+1)'(x0);
   assign dy  = (C+1)'(y1) - (C+1)'(y0);
   assign ew_in  = (dx > 0) ? dx[C-1:0] : '0;
   assign eh_in  = (dy > 0) ? dy[C-1:0] : '0;
   assign box_in = {y1, x1, y0, x0};

   assign pos       = req_tuser[0] ? 16'd0 : setpos_ff;
   assign setpos_in = (pos == 16'hFFFF) ? pos : pos + 16'd1;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_AREA;
               if (req_tuser[0]) begin
                  count_in = '0;
               end
            end
         end
         ST_AREA: begin
            addr_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_fire) begin
               addr_in = addr_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!scan_stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         count_ff     <= '0;
         addr_ff      <= '0;
         setpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_wdata;
         end
         if (req_fire) begin
            setpos_ff <= setpos_in;
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         box_ff <= box_in;
         ew_ff  <= ew_in;
         eh_ff  <= eh_in;
         idx_ff <= pos;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= (2*C)'(ew_ff) * (2*C)'(eh_ff);
      end
      if (done_fire) begin
         rsp_keep_ff <= keep;
         rsp_full_ff <= keep & ~room;
         rsp_idx_ff  <= idx_ff;
         rsp_slot_ff <= wr_en ? slot_wide[SLOT_BITS-1:0] : '0;
      end
   end

   gbn_ram #(
      .WIDTH (4 * C),
      .DEPTH (MAX_KEPT)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (box_ff),
      .rd_en   (rd_fire),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (kbox_rd)
   );

   gbn_ram #(
      .WIDTH (2 * C),
      .DEPTH (MAX_KEPT)
   ) u_area_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (area_ff),
      .rd_en   (rd_fire),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (karea_rd)
   );

   gbn_scan #(
      .COORD_BITS (C)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_AREA),
      .rd_fire   (rd_fire),
      .cur_box   (box_ff),
      .cur_area  (area_ff),
      .thr       (thr_ff),
      .kept_box  (kbox_rd),
      .kept_area (karea_rd),
      .stat      (scan_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_slot_ff, rsp_idx_ff};
   assign rsp_tuser  = {rsp_full_ff, rsp_keep_ff};

endmodule

[rtl/core/gbn_checker.sv]
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the suppression core, bound to its top level.
// ----------------------------------------------------------------------------
module gbn_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [gbn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [gbn_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // A suppressed box reports neither a slot nor a full store.
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1] && rsp_tdata[21:16] == 6'd0)
      else $error("suppressed box carries slot or full flag");

   // A box that did not fit in the store was not given a slot.
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[21:16] == 6'd0)
      else $error("full store reported with a slot");

   // Boxes are handled one at a time: an accepted request blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // No response is presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind greedy_box_nms_core gbn_checker u_gbn_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives score-ordered boxes into greedy_box_nms_core and checks every response
// against a cycle-free model of greedy suppression with a bounded kept-box store.
// Both stream sides idle and stall at random, and the IoU threshold is rewritten
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module testbench;
   import gbn_pkg::*;

   localparam int MAX_KEPT  = 64;
   localparam int SET_LIMIT = 65535;
   localparam int MAX_SHOWN = 40;

   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_COMB, DRAIN_TRICKLE} drain_mode_type;

   typedef struct packed {
      logic        keep;
      logic        full;
      logic [5:0]  slot;
      logic [15:0] index;
   } verdict_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [THR_BITS-1:0]   csr_wdata  = '0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;

   // Model state: threshold, kept boxes with their areas, and the set position.
   logic [THR_BITS-1:0] iou_thr = THR_RESET;
   int                  kept_x0 [MAX_KEPT];
   int                  kept_y0 [MAX_KEPT];
   int                  kept_x1 [MAX_KEPT];
   int                  kept_y1 [MAX_KEPT];
   longint              kept_area [MAX_KEPT];
   int                  kept_total = 0;
   int                  set_pos    = 0;

   verdict_type         expected_verdicts [$];
   verdict_type         oldest;
   int                  fail_count = 0;

   logic                pace_on    = 1'b0;
   int                  burst_left = 0;
   logic                stall_on   = 1'b0;
   drain_mode_type      drain_mode = DRAIN_FREE;
   int                  drain_left = 0;
   int                  drain_tick = 0;

   always #4 clock = ~clock;

   greedy_box_nms_core #(
      .MAX_KEPT   (MAX_KEPT),
      .COORD_BITS (16)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wdata  (csr_wdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   function automatic longint span(input int lo, input int hi);
      return (hi > lo) ? longint'(hi - lo) : 64'sd0;
   endfunction

   function automatic longint common_span(input int lo_a, input int hi_a,
                                          input int lo_b, input int hi_b);
      return span((lo_a > lo_b) ? lo_a : lo_b, (hi_a < hi_b) ? hi_a : hi_b);
   endfunction

   task automatic predict_verdict(input logic first, input logic [REQ_DATA_W-1:0] edges,
                                  output verdict_type v);
      int     bx0, by0, bx1, by1, k;
      longint area, inter, uni;
      logic   keep;
      if (first) begin
         kept_total = 0;
         set_pos    = 0;
      end
      bx0  = $signed(edges[15:0]);
      by0  = $signed(edges[31:16]);
      bx1  = $signed(edges[47:32]);
      by1  = $signed(edges[63:48]);
      area = span(bx0, bx1) * span(by0, by1);
      v       = '0;
      v.index = set_pos[15:0];
      if (set_pos < SET_LIMIT) set_pos++;
      keep = 1'b1;
      for (k = 0; k < kept_total; k++) begin
         inter = common_span(bx0, bx1, kept_x0[k], kept_x1[k])
               * common_span(by0, by1, kept_y0[k], kept_y1[k]);
         uni   = area + kept_area[k] - inter;
         // IoU > thr/2^16 evaluated exactly as inter * 2^16 > thr * union.
         if (uni != 0 && inter * 65536 > longint'(iou_thr) * uni) keep = 1'b0;
      end
      v.keep = keep;
      if (keep) begin
         if (kept_total < MAX_KEPT) begin
            kept_x0[kept_total]   = bx0;
            kept_y0[kept_total]   = by0;
            kept_x1[kept_total]   = bx1;
            kept_y1[kept_total]   = by1;
            kept_area[kept_total] = area;
            v.slot                = kept_total[5:0];
            kept_total++;
         end else begin
            v.full = 1'b1;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      if (fail_count < MAX_SHOWN)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("response with no request pending", rsp_tdata, 0);
         end else begin
            oldest = expected_verdicts.pop_front();
            if (rsp_tuser[0] !== oldest.keep)
               report_mismatch("keep", rsp_tuser[0], oldest.keep);
            if (rsp_tuser[1] !== oldest.full)
               report_mismatch("store_full", rsp_tuser[1], oldest.full);
            if (rsp_tdata[15:0] !== oldest.index)
               report_mismatch("box_index", rsp_tdata[15:0], oldest.index);
            if (rsp_tdata[21:16] !== oldest.slot)
               report_mismatch("kept_slot", rsp_tdata[21:16], oldest.slot);
            if (rsp_tdata[23:22] !== 2'b00)
               report_mismatch("tdata fill", rsp_tdata[23:22], 0);
         end
      end
   end

   // The receiver switches at random between back-pressure patterns.
   always @(negedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         drain_left = $urandom_range(20, 300);
      end
      drain_left--;
      drain_tick++;
      if (!stall_on) begin
         rsp_tready = 1'b1;
      end else begin
         case (drain_mode)
            DRAIN_FREE:  rsp_tready = 1'b1;
            DRAIN_COIN:  rsp_tready = 1'($urandom_range(0, 1));
            DRAIN_COMB:  rsp_tready = (drain_tick % 5) < 2;
            default:     rsp_tready = ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   task automatic send_box(input logic first, input int x0, input int y0,
                           input int x1, input int y1);
      int          gap;
      verdict_type v;
      if (pace_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      @(negedge clock);
      req_tuser  = first;
      req_tdata  = {16'(y1), 16'(x1), 16'(y0), 16'(x0)};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_verdict(first, req_tdata, v);
      expected_verdicts = {expected_verdicts, v};
   endtask

   task automatic await_idle(input int settle);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      await_idle(12);
      @(negedge clock);
      csr_wdata = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      iou_thr = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Reset threshold: duplicates, touching and inverted boxes, zero union, full range.
   task automatic test_directed_boxes();
      pace_on  = 1'b1;
      stall_on = 1'b1;
      send_box(1'b1, 0, 0, 160, 160);
      send_box(1'b0, 0, 0, 160, 160);
      send_box(1'b0, 160, 0, 320, 160);
      send_box(1'b0, 100, 100, 50, 50);
      send_box(1'b0, 100, 100, 50, 50);
      send_box(1'b0, 40, 0, 200, 160);
      send_box(1'b0, 80, 0, 240, 160);
      send_box(1'b0, -32768, -32768, 32767, 32767);
      send_box(1'b0, 32767, 32767, -32768, -32768);
      send_box(1'b0, -32768, -32768, 32767, 32767);
      send_box(1'b0, -32768, 0, -32752, 16);
      send_box(1'b0, 32751, -16, 32767, 0);
      send_box(1'b1, 0, 0, 160, 160);
      send_box(1'b0, 0, 0, 160, 161);
      send_box(1'b0, -21846, 21845, -21000, 22000);
   endtask

   task automatic test_threshold_extremes();
      // Zero threshold: any overlap at all suppresses.
      write_threshold(16'd0);
      send_box(1'b1, 0, 0, 32, 32);
      send_box(1'b0, 31, 31, 64, 64);
      send_box(1'b0, 32, 0, 64, 32);
      send_box(1'b0, 16, 16, 16, 40);
      // Full-scale threshold: only a near-identical box is suppressed.
      write_threshold(16'hFFFF);
      send_box(1'b1, 0, 0, 32, 32);
      send_box(1'b0, 0, 0, 32, 32);
      send_box(1'b0, 0, 0, 32, 33);
      send_box(1'b0, 1, 0, 32, 32);
   endtask

   // Zero-area boxes never suppress each other, so they overflow the store.
   task automatic test_store_overflow();
      int i;
      write_threshold(THR_RESET);
      send_box(1'b1, 0, 0, 0, 50);
      for (i = 1; i < MAX_KEPT + 3; i++)
         send_box(1'b0, 16 * i, 0, 16 * i, 50);
      send_box(1'b0, 0, 0, 100, 100);
      send_box(1'b0, 0, 0, 100, 100);
      send_box(1'b1, 0, 0, 100, 100);
      send_box(1'b0, 0, 0, 100, 100);
   endtask

   task automatic test_random_sets();
      logic [THR_BITS-1:0] thr_plan [6];
      int   phase, in_phase, len, pick, bx, by, w, h, x0, y0, i, grid_pos;
      logic broken;
      thr_plan    = '{THR_RESET, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd32768};
      thr_plan[3] = 16'($urandom_range(0, 65535));
      thr_plan[4] = 16'($urandom_range(0, 65535));
      pace_on     = 1'b1;
      stall_on    = 1'b1;
      for (phase = 0; phase < 6; phase++) begin
         write_threshold(thr_plan[phase]);
         in_phase = 0;
         while (in_phase < 300) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               send_box(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
               in_phase++;
            end else if (pick < 19) begin
               // Mostly distinct grid cells with a few repeats, enough to fill the store.
               len = $urandom_range(66, 80);
               bx  = $urandom_range(0, 59000) - 30000;
               by  = $urandom_range(0, 59000) - 30000;
               for (i = 0; i < len; i++) begin
                  grid_pos = (i > 0 && $urandom_range(0, 7) == 0) ?
                             $urandom_range(0, i - 1) : i;
                  x0   = bx + (grid_pos % 10) * 64;
                  y0   = by + (grid_pos / 10) * 64;
                  send_box(i == 0, x0, y0, x0 + $urandom_range(40, 60),
                           y0 + $urandom_range(40, 60));
               end
               in_phase += len;
            end else begin
               // A cluster of overlapping boxes; some sets lack the opening flag.
               len    = $urandom_range(1, 30);
               bx     = $urandom_range(0, 60000) - 30000;
               by     = $urandom_range(0, 60000) - 30000;
               broken = ($urandom_range(0, 9) == 0);
               for (i = 0; i < len; i++) begin
                  x0 = bx + $urandom_range(0, 600);
                  y0 = by + $urandom_range(0, 600);
                  w  = $urandom_range(0, 800);
                  h  = $urandom_range(0, 800);
                  if ($urandom_range(0, 19) == 0)
                     send_box(i == 0 && !broken, x0 + w, y0 + h, x0, y0);
                  else
                     send_box(i == 0 && !broken, x0, y0, x0 + w, y0 + h);
               end
               in_phase += len;
            end
            if ($urandom_range(0, 49) == 0) await_idle(0);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_boxes();
      test_threshold_extremes();
      test_store_overflow();
      test_random_sets();
      await_idle(80);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
